### hdl/go_back_n_receiver_ack_unit_macros.svh
// Assertion macros for the Go-Back-N receiver acknowledgement unit.
// Included by the top level; relies on nothing but the language itself.
`ifndef GO_BACK_N_RECEIVER_ACK_UNIT_MACROS_SVH
`define GO_BACK_N_RECEIVER_ACK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBNR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gbnr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBNR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gbnr assertion failed");

`endif

### hdl/gbnr_pkg.sv
// Shared types and constants of the Go-Back-N receiver acknowledgement unit.
// No dependencies; every other file but the macro header imports it.
`default_nettype none

package gbnr_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_INIT = 2'd0;
    localparam t_kind KIND_ACK  = 2'd1;
    localparam t_kind KIND_LOSS = 2'd2;

    localparam int unsigned CFG_IDX_BITS = 2;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ACK_INTERVAL = 2'd0;
    localparam t_cfg_idx CFG_WINDOW_SIZE  = 2'd1;

    localparam logic [3:0] ACK_INTERVAL_RESET = 4'd3;
    localparam logic [7:0] WINDOW_SIZE_RESET  = 8'd4;

    typedef struct packed {
        logic [7:0] seq_no;
        logic       lost;
    } t_pkt;

    typedef struct packed {
        t_kind      reply_kind;
        logic [7:0] ack_no;
        logic       loss_flag;
        logic [7:0] window_out;
    } t_reply;

    typedef struct packed {
        logic   valid;
        t_reply reply;
    } t_result;

endpackage

`default_nettype wire

### hdl/gbnr_if.sv
// Handshake channel interfaces: packet input, reply output, configuration writes.
// Depends on gbnr_pkg.
`default_nettype none

interface gbnr_pkt_if import gbnr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] seq_no;
    logic       lost;

    modport source (output valid, output seq_no, output lost, input ready);
    modport sink (input valid, input seq_no, input lost, output ready);
endinterface

interface gbnr_reply_if import gbnr_pkg::*; ();
    logic       valid;
    logic       ready;
    t_kind      reply_kind;
    logic [7:0] ack_no;
    logic       loss_flag;
    logic [7:0] window_out;

    modport source (output valid, output reply_kind, output ack_no, output loss_flag,
                    output window_out, input ready);
    modport sink (input valid, input reply_kind, input ack_no, input loss_flag,
                  input window_out, output ready);
endinterface

interface gbnr_cfg_if import gbnr_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cfg_idx   index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/gbnr_core.sv
// Receiver state and the per-packet decision logic (one packet per step).
// Depends on gbnr_pkg.
`default_nettype none

module gbnr_core import gbnr_pkg::*; #(
    parameter int unsigned SEQ_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire t_pkt       i_pkt,
    input  wire logic [3:0] i_ack_interval,
    input  wire logic [7:0] i_window_size,
    output t_result         o_result
);

    localparam int unsigned CW = ((SEQ_BITS > 8) ? SEQ_BITS : 8) + 1;
    localparam logic [7:0] SEQ_MASK8 =
        (SEQ_BITS >= 8) ? 8'hFF : 8'((1 << SEQ_BITS) - 1);
    localparam logic [CW-1:0] SEQ_TOP = CW'((1 << SEQ_BITS) - 1);

    logic [SEQ_BITS-1:0] r_in_order, n_in_order;
    logic [7:0]          r_last_seen, n_last_seen;
    logic [4:0]          r_pkt_cnt, n_pkt_cnt;
    logic [7:0]          r_missing, n_missing;
    logic                r_loss_pend, n_loss_pend;
    logic                r_wrap_pend, n_wrap_pend;
    logic                r_init_sent, n_init_sent;
    logic                r_win_known, n_win_known;

    always_comb begin
        logic [7:0] seq;
        logic       run;
        logic       match;
        t_result    res;

        seq = i_pkt.seq_no & SEQ_MASK8;
        run = 1'b0;
        match = 1'b0;
        res = '0;

        n_in_order  = r_in_order;
        n_last_seen = r_last_seen;
        n_pkt_cnt   = r_pkt_cnt;
        n_missing   = r_missing;
        n_loss_pend = r_loss_pend;
        n_wrap_pend = r_wrap_pend;
        n_init_sent = r_init_sent;
        n_win_known = r_win_known;

        // A lost packet is reported only when no loss is outstanding or it
        // repeats the outstanding number; otherwise it is dropped silently.
        if (i_pkt.lost) begin
            if (r_missing == 8'd0 || r_missing == seq) begin
                n_loss_pend = 1'b1;
                run = 1'b1;
            end
        end else begin
            run = 1'b1;
            if (seq == 8'd0) begin
                n_win_known = 1'b1;
            end else begin
                n_last_seen = seq;
                if (seq == 8'd1 && r_wrap_pend) begin
                    n_wrap_pend = 1'b0;
                    n_in_order = '0;
                end
            end
        end

        if (run) begin
            if (!n_init_sent) begin
                n_init_sent = 1'b1;
                res.valid = 1'b1;
                res.reply.reply_kind = KIND_INIT;
            end else if (n_loss_pend) begin
                n_loss_pend = 1'b0;
                n_pkt_cnt = '0;
                res.valid = 1'b1;
                res.reply.reply_kind = KIND_LOSS;
                res.reply.loss_flag = 1'b1;
            end else begin
                if (n_missing != 8'd0 && n_missing == n_last_seen) begin
                    n_missing = 8'd0;
                end
                // Once the counter is past the interval it stays locked until
                // a loss notice clears it.
                if (n_missing == 8'd0 && n_pkt_cnt <= {1'b0, i_ack_interval}) begin
                    n_pkt_cnt = 5'(n_pkt_cnt + 5'd1);
                    match = (CW'(n_last_seen) == CW'(n_in_order) + CW'(1));
                    if (match && n_pkt_cnt <= {1'b0, i_ack_interval}) begin
                        if (CW'(n_last_seen) == SEQ_TOP) begin
                            n_wrap_pend = 1'b1;
                        end
                        n_in_order = SEQ_BITS'(n_in_order + SEQ_BITS'(1));
                        if (n_pkt_cnt == {1'b0, i_ack_interval}) begin
                            n_pkt_cnt = '0;
                            res.valid = 1'b1;
                            res.reply.reply_kind = KIND_ACK;
                        end
                    end
                end
            end
            res.reply.ack_no = 8'(n_in_order);
            res.reply.window_out = n_win_known ? i_window_size : 8'd0;
            if (i_pkt.lost) begin
                n_missing = seq;
            end
        end

        o_result = res;
        o_result.valid = res.valid & i_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_order  <= '0;
            r_last_seen <= '0;
            r_pkt_cnt   <= '0;
            r_missing   <= '0;
            r_loss_pend <= 1'b0;
            r_wrap_pend <= 1'b0;
            r_init_sent <= 1'b0;
            r_win_known <= 1'b0;
        end else if (i_step) begin
            r_in_order  <= n_in_order;
            r_last_seen <= n_last_seen;
            r_pkt_cnt   <= n_pkt_cnt;
            r_missing   <= n_missing;
            r_loss_pend <= n_loss_pend;
            r_wrap_pend <= n_wrap_pend;
            r_init_sent <= n_init_sent;
            r_win_known <= n_win_known;
        end
    end

endmodule

`default_nettype wire

### hdl/gbnr_out_reg.sv
// Result register that holds one reply until the downstream transfer completes.
// Depends on gbnr_pkg and gbnr_reply_if.
`default_nettype none

module gbnr_out_reg import gbnr_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_result   i_result,
    output logic           o_free,
    gbnr_reply_if.source   o_reply
);

    logic   r_valid;
    t_reply r_reply;

    assign o_free = !r_valid || o_reply.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_result.valid) begin
            r_reply <= i_result.reply;
        end
    end

    assign o_reply.valid      = r_valid;
    assign o_reply.reply_kind = r_reply.reply_kind;
    assign o_reply.ack_no     = r_reply.ack_no;
    assign o_reply.loss_flag  = r_reply.loss_flag;
    assign o_reply.window_out = r_reply.window_out;

endmodule

`default_nettype wire

### hdl/go_back_n_receiver_ack_unit.sv
// Top level of the Go-Back-N receiver acknowledgement unit.
// Depends on gbnr_pkg, the channel interfaces, gbnr_core, gbnr_out_reg and the macro header.
`default_nettype none

`include "go_back_n_receiver_ack_unit_macros.svh"

// One packet is taken per cycle unless a stalled reply holds the flow. A
// packet is registered on its transfer, then decided by the state update in
// gbnr_core once the result register is free, and its reply, if any, is
// loaded into the result register by that same update. Packets that cause no
// reply are absorbed without output. While a reply waits in the result
// register the unit still takes one more packet into its input register; only
// then does ready drop. Configuration writes are always accepted and take
// effect at once; change them only while no packet is in flight. No clearing
// pass is needed after reset.
module go_back_n_receiver_ack_unit import gbnr_pkg::*; #(
    parameter int unsigned SEQ_BITS = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gbnr_pkt_if.sink     i_pkt,
    gbnr_cfg_if.sink     i_cfg,
    gbnr_reply_if.source o_reply
);

    logic [3:0] r_ack_interval;
    logic [7:0] r_window_size;
    logic       r_in_valid;
    t_pkt       r_pkt;
    logic       out_free;
    logic       advance;
    t_result    result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_interval <= ACK_INTERVAL_RESET;
            r_window_size  <= WINDOW_SIZE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ACK_INTERVAL: r_ack_interval <= i_cfg.data[3:0];
                CFG_WINDOW_SIZE:  r_window_size  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign advance     = r_in_valid && out_free;
    assign i_pkt.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pkt.ready) begin
            r_in_valid <= i_pkt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt.valid && i_pkt.ready) begin
            r_pkt.seq_no <= i_pkt.seq_no;
            r_pkt.lost   <= i_pkt.lost;
        end
    end

    gbnr_core #(
        .SEQ_BITS (SEQ_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_pkt          (r_pkt),
        .i_ack_interval (r_ack_interval),
        .i_window_size  (r_window_size),
        .o_result       (result)
    );

    gbnr_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_free   (out_free),
        .o_reply  (o_reply)
    );

    `GBNR_ASSERT_NOW(a_stall_backs_up, i_clk, i_rst_n, r_in_valid && o_reply.valid && !o_reply.ready, !i_pkt.ready)
    `GBNR_ASSERT_NOW(a_loss_flag_kind, i_clk, i_rst_n, o_reply.valid, o_reply.loss_flag == (o_reply.reply_kind == KIND_LOSS))
    `GBNR_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_pkt.valid && i_pkt.ready, r_in_valid)
    `GBNR_ASSERT_NOW(a_result_needs_item, i_clk, i_rst_n, result.valid, r_in_valid && out_free)

endmodule

`default_nettype wire

### tb/tb_go_back_n_receiver_ack_unit.sv
// Self-checking testbench of the Go-Back-N receiver acknowledgement unit.
// Needs gbnr_pkg, the channel interfaces of gbnr_if.sv and the unit's RTL;
// replies are checked against an in-bench model of the acknowledgement logic.
module tb_go_back_n_receiver_ack_unit import gbnr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF_NS     = 5;
    localparam int          RESET_CYCLES    = 8;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          PHASES          = 6;
    localparam int          ITEMS_PER_PHASE = 300;
    localparam int          DIR_ROWS        = 31;
    localparam logic [7:0]  SEQ_TOP         = 8'hFF;

    // Index with no register behind it; a write there changes nothing.
    localparam t_cfg_idx CFG_SPARE = 2'd2;

    typedef enum logic {STEP_PKT, STEP_CFG} t_step_op;

    // One row of the directed plan. Packet rows ignore idx; configuration
    // rows use val as write data. Rows with typed set carry their own reply.
    typedef struct packed {
        t_step_op   op;
        t_cfg_idx   idx;
        logic [7:0] val;
        logic       lost;
        logic       typed;
        logic       want_reply;
        t_reply     want;
    } t_dir_row;

    localparam t_reply FROM_MODEL = '0;

    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // A lost packet before anything else: the initial reply goes first.
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'hFF, 1'b1, 1'b1, 1'b1, '{KIND_INIT, 8'd0, 1'b0, 8'd0}},
        // The request then flushes the pending loss notice with the window.
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h00, 1'b0, 1'b1, 1'b1, '{KIND_LOSS, 8'd0, 1'b1, 8'd4}},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'hFF, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h01, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h02, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h07, 1'b1, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h08, 1'b1, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h07, 1'b1, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h03, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h07, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h03, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h04, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h00, 1'b1, 1'b0, 1'b0, FROM_MODEL},
        // Out-of-order packets push the counter past the interval and lock it.
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h09, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h09, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h09, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h09, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h05, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h05, 1'b1, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h05, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_CFG, CFG_WINDOW_SIZE,  8'h00, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_CFG, CFG_ACK_INTERVAL, 8'hF1, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_CFG, CFG_SPARE,        8'hA5, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h06, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_CFG, CFG_ACK_INTERVAL, 8'h00, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h07, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h07, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h09, 1'b1, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_CFG, CFG_ACK_INTERVAL, 8'hFF, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_CFG, CFG_WINDOW_SIZE,  8'hFF, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{STEP_PKT, CFG_ACK_INTERVAL, 8'h09, 1'b0, 1'b0, 1'b0, FROM_MODEL}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    gbnr_pkt_if   pkt ();
    gbnr_cfg_if   cfg ();
    gbnr_reply_if rpl ();

    go_back_n_receiver_ack_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt),
        .i_cfg   (cfg),
        .o_reply (rpl)
    );

    // Receiver-side state of the model.
    logic [7:0] rx_in_order;
    logic [7:0] rx_last_seen;
    logic [4:0] rx_count;
    logic [7:0] rx_missing;
    logic       rx_loss_due;
    logic       rx_wrap_due;
    logic       rx_init_done;
    logic       rx_window_seen;
    logic [3:0] cur_ack_interval;
    logic [7:0] cur_window;

    t_reply replies_due [$];
    int     fail_count    = 0;
    int     src_idle_pct  = 19;
    int     sink_idle_pct = 83;

    always begin
        #(CLK_HALF_NS) i_clk = 1'b1;
        #(CLK_HALF_NS) i_clk = 1'b0;
    end

    function automatic t_reply reply_of(input t_kind kind, input logic loss);
        t_reply rep;
        rep.reply_kind = kind;
        rep.ack_no     = rx_in_order;
        rep.loss_flag  = loss;
        rep.window_out = rx_window_seen ? cur_window : 8'd0;
        return rep;
    endfunction

    // Reply decision once a packet has updated the receiver state.
    function automatic logic decide_reply(output t_reply rep);
        logic in_step;
        rep = '0;
        if (!rx_init_done) begin
            rx_init_done = 1'b1;
            rep = reply_of(KIND_INIT, 1'b0);
            return 1'b1;
        end
        if (rx_loss_due) begin
            rep = reply_of(KIND_LOSS, 1'b1);
            rx_loss_due = 1'b0;
            rx_count = '0;
            return 1'b1;
        end
        if (rx_missing != 8'd0 && rx_missing == rx_last_seen)
            rx_missing = 8'd0;
        if (rx_missing != 8'd0 || rx_count > {1'b0, cur_ack_interval})
            return 1'b0;
        rx_count = rx_count + 5'd1;
        // An in-order count at the top value never matches: in_order + 1 leaves 8 bits.
        in_step = ({1'b0, rx_last_seen} == {1'b0, rx_in_order} + 9'd1);
        if (in_step && rx_count < {1'b0, cur_ack_interval}) begin
            if (rx_last_seen == SEQ_TOP)
                rx_wrap_due = 1'b1;
            rx_in_order = rx_in_order + 8'd1;
            return 1'b0;
        end
        if (in_step && rx_count == {1'b0, cur_ack_interval}) begin
            rx_count = '0;
            rx_in_order = rx_in_order + 8'd1;
            if (rx_last_seen == SEQ_TOP)
                rx_wrap_due = 1'b1;
            rep = reply_of(KIND_ACK, 1'b0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic predict_reply(input logic [7:0] seq, input logic lost,
                                           output t_reply rep);
        logic has;
        rep = '0;
        if (lost) begin
            // A second lost number is dropped while another loss is outstanding.
            if (rx_missing != 8'd0 && rx_missing != seq)
                return 1'b0;
            rx_loss_due = 1'b1;
            has = decide_reply(rep);
            rx_missing = seq;
            return has;
        end
        if (seq == 8'd0) begin
            rx_window_seen = 1'b1;
        end else begin
            rx_last_seen = seq;
            if (seq == 8'd1 && rx_wrap_due) begin
                rx_wrap_due = 1'b0;
                rx_in_order = 8'd0;
            end
        end
        return decide_reply(rep);
    endfunction

    // Mostly well-formed traffic: the next in-order packet, losses followed by
    // retransmission, and a loss when the counter is locked up, bar random picks.
    function automatic void choose_pkt(output logic [7:0] seq, output logic lost);
        int unsigned roll;
        logic [7:0]  next_seq;
        roll = $urandom_range(99);
        next_seq = (rx_in_order == SEQ_TOP) ? 8'd1 : rx_in_order + 8'd1;
        seq = next_seq;
        lost = 1'b0;
        if (roll < 10) begin
            seq = 8'($urandom_range(255));
            lost = 1'($urandom_range(1));
        end else if (rx_count > {1'b0, cur_ack_interval}) begin
            lost = 1'b1;
            if (rx_missing != 8'd0)
                seq = rx_missing;
        end else if (rx_missing != 8'd0) begin
            if (roll < 80) begin
                seq = rx_missing;
            end else if (roll < 90) begin
                seq = rx_missing;
                lost = 1'b1;
            end
        end else if (roll < 16) begin
            lost = 1'b1;
        end else if (roll < 18) begin
            seq = 8'd0;
        end
    endfunction

    function automatic void cmp_field(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_pkt(input logic [7:0] seq, input logic lost);
        while ($urandom_range(99) < src_idle_pct) begin
            pkt.valid <= 1'b0;
            @(negedge i_clk);
        end
        pkt.valid  <= 1'b1;
        pkt.seq_no <= seq;
        pkt.lost   <= lost;
        do @(posedge i_clk); while (!pkt.ready);
        @(negedge i_clk);
    endtask

    task automatic push_prediction(input logic [7:0] seq, input logic lost);
        t_reply rep;
        if (predict_reply(seq, lost, rep))
            replies_due.push_back(rep);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] data);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            CFG_ACK_INTERVAL: cur_ack_interval = data[3:0];
            CFG_WINDOW_SIZE:  cur_window = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // Stop sending and let every reply drain, then give a packet that causes
    // no reply time to pass through the pipeline.
    task automatic quiesce();
        pkt.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        rpl.ready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && rpl.valid && rpl.ready) begin
            if (replies_due.size() == 0) begin
                $error("reply with no packet waiting for one: kind %0d ack_no %0d",
                       rpl.reply_kind, rpl.ack_no);
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                cmp_field("reply_kind", want.reply_kind, rpl.reply_kind);
                cmp_field("ack_no", want.ack_no, rpl.ack_no);
                cmp_field("loss_flag", want.loss_flag, rpl.loss_flag);
                cmp_field("window_out", want.window_out, rpl.window_out);
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("go_back_n_receiver_ack_unit test failed");
        $finish;
    end

    initial begin
        t_reply     rep;
        logic       has;
        logic [7:0] seq;
        logic       lost;
        logic [7:0] ai_data;
        logic [7:0] ws_data;

        i_rst_n    = 1'b0;
        pkt.valid  = 1'b0;
        pkt.seq_no = 8'd0;
        pkt.lost   = 1'b0;
        cfg.valid  = 1'b0;
        cfg.index  = CFG_ACK_INTERVAL;
        cfg.data   = 8'd0;
        rpl.ready  = 1'b0;

        rx_in_order      = 8'd0;
        rx_last_seen     = 8'd0;
        rx_count         = '0;
        rx_missing       = 8'd0;
        rx_loss_due      = 1'b0;
        rx_wrap_due      = 1'b0;
        rx_init_done     = 1'b0;
        rx_window_seen   = 1'b0;
        cur_ack_interval = ACK_INTERVAL_RESET;
        cur_window       = WINDOW_SIZE_RESET;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].op == STEP_CFG) begin
                quiesce();
                write_reg(DIRECTED[i].idx, DIRECTED[i].val);
            end else begin
                send_pkt(DIRECTED[i].val, DIRECTED[i].lost);
                has = predict_reply(DIRECTED[i].val, DIRECTED[i].lost, rep);
                if (DIRECTED[i].typed) begin
                    has = DIRECTED[i].want_reply;
                    rep = DIRECTED[i].want;
                end
                if (has)
                    replies_due.push_back(rep);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            case (ph)
                0: begin ai_data = 8'h02; ws_data = 8'hFF; end
                1: begin ai_data = 8'h31; ws_data = 8'h00; end
                2: begin ai_data = 8'h0F; ws_data = 8'h80; end
                3: begin ai_data = 8'hE0; ws_data = 8'h7F; end
                default: begin
                    ai_data = 8'($urandom_range(255));
                    ws_data = 8'($urandom_range(255));
                end
            endcase
            if (ph < 2) begin
                src_idle_pct  = 19;
                sink_idle_pct = 83;
            end else if (ph < 4) begin
                src_idle_pct  = 83;
                sink_idle_pct = 19;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_reg(CFG_ACK_INTERVAL, ai_data);
            write_reg(CFG_WINDOW_SIZE, ws_data);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                choose_pkt(seq, lost);
                send_pkt(seq, lost);
                push_prediction(seq, lost);
            end
        end

        quiesce();
        if (replies_due.size() != 0) begin
            $error("%0d expected replies never arrived", replies_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("go_back_n_receiver_ack_unit test passed");
        else
            $display("go_back_n_receiver_ack_unit test failed");
        $finish;
    end

endmodule
